/* hw/rtl/cdiv_pkg.sv */
package cdiv_pkg;

  // Default word format: signed Q8.8
  localparam int WIDTH     = 16;
  localparam int FRAC_BITS = 8;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_SAT  = 2'd2
  } status_e;

endpackage

/* hw/rtl/complex_divider.sv */
// Complex divider, fully pipelined.
// Pipeline: an accepted input word passes two multiply/sum stages, WIDTH+3 divider stages
// and the output register before it appears as an output word.
// Throughput: one word per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous active-low reset clears all valid bits; data registers are not reset.
module complex_divider #(
  parameter int WIDTH     = cdiv_pkg::WIDTH,
  parameter int FRAC_BITS = cdiv_pkg::FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [WIDTH-1:0] dividend_re_i,
  input  logic signed [WIDTH-1:0] dividend_im_i,
  input  logic signed [WIDTH-1:0] divisor_re_i,
  input  logic signed [WIDTH-1:0] divisor_im_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [WIDTH-1:0] quot_re_o,
  output logic signed [WIDTH-1:0] quot_im_o,
  output logic [1:0]              status_o
);

  localparam int W       = WIDTH;
  localparam int DIV_LAT = W + 3;
  localparam int LAT     = DIV_LAT + 3;

  logic en;
  logic out_valid_q;

  // Advance everything unless the output word is held
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits travel with the data
  logic [LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_q = vld_q[LAT-1];

  // Stage 1: products
  logic signed [2*W-1:0] p_arbr_q, p_aibi_q, p_brai_q, p_arbi_q, p_brbr_q, p_bibi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_arbr_q <= dividend_re_i * divisor_re_i;
      p_aibi_q <= dividend_im_i * divisor_im_i;
      p_brai_q <= divisor_re_i * dividend_im_i;
      p_arbi_q <= dividend_re_i * divisor_im_i;
      p_brbr_q <= divisor_re_i * divisor_re_i;
      p_bibi_q <= divisor_im_i * divisor_im_i;
    end
  end

  // Stage 2: numerators and denominator
  logic signed [2*W:0] nre_q, nim_q;
  logic [2*W-1:0]      den_q;
  logic [2*W-1:0]      den_d;

  assign den_d = $unsigned(p_brbr_q) + $unsigned(p_bibi_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nre_q <= (2*W+1)'(p_arbr_q) + (2*W+1)'(p_aibi_q);
      nim_q <= (2*W+1)'(p_brai_q) - (2*W+1)'(p_arbi_q);
      den_q <= den_d;
    end
  end

  // Carry the zero-divisor flag alongside the divider
  logic [DIV_LAT-1:0] zero_q;
  logic               zero_s2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_s2_q <= (den_d == '0);
      zero_q    <= {zero_q[DIV_LAT-2:0], zero_s2_q};
    end
  end

  // Divider lanes
  logic [W:0] quo_re, quo_im;
  logic       neg_re, neg_im, ovf_re, ovf_im;

  cdiv_div #(.W(W), .F(FRAC_BITS)) u_div_re (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nre_q),
    .den_i (den_q),
    .quo_o (quo_re),
    .neg_o (neg_re),
    .ovf_o (ovf_re)
  );

  cdiv_div #(.W(W), .F(FRAC_BITS)) u_div_im (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nim_q),
    .den_i (den_q),
    .quo_o (quo_im),
    .neg_o (neg_im),
    .ovf_o (ovf_im)
  );

  // Saturate each lane to the signed range
  localparam logic [W:0] SIGN_MAG = (W+1)'(1) << (W - 1);

  logic signed [W-1:0] sat_re_val, sat_im_val;
  logic                sat_re, sat_im;

  always_comb begin
    if (neg_re) begin
      sat_re     = ovf_re || (quo_re > SIGN_MAG);
      sat_re_val = sat_re ? {1'b1, {(W-1){1'b0}}} : W'(-quo_re);
    end else begin
      sat_re     = ovf_re || (quo_re >= SIGN_MAG);
      sat_re_val = sat_re ? {1'b0, {(W-1){1'b1}}} : quo_re[W-1:0];
    end
    if (neg_im) begin
      sat_im     = ovf_im || (quo_im > SIGN_MAG);
      sat_im_val = sat_im ? {1'b1, {(W-1){1'b0}}} : W'(-quo_im);
    end else begin
      sat_im     = ovf_im || (quo_im >= SIGN_MAG);
      sat_im_val = sat_im ? {1'b0, {(W-1){1'b1}}} : quo_im[W-1:0];
    end
  end

  // Output register
  logic signed [W-1:0] quot_re_q, quot_im_q;
  logic [1:0]          status_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_q[DIV_LAT-1]) begin
        quot_re_q <= '0;
        quot_im_q <= '0;
        status_q  <= cdiv_pkg::STAT_ZERO;
      end else begin
        quot_re_q <= sat_re_val;
        quot_im_q <= sat_im_val;
        status_q  <= (sat_re || sat_im) ? cdiv_pkg::STAT_SAT : cdiv_pkg::STAT_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign quot_re_o   = quot_re_q;
  assign quot_im_o   = quot_im_q;
  assign status_o    = status_q;

endmodule

/* hw/rtl/cdiv_div.sv */
// Pipelined restoring divider for one quotient lane: one quotient bit per stage.
module cdiv_div #(
  parameter int W = cdiv_pkg::WIDTH,
  parameter int F = cdiv_pkg::FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [2*W:0] num_i,
  input  logic [2*W-1:0]      den_i,
  output logic [W:0]          quo_o,
  output logic                neg_o,
  output logic                ovf_o
);

  localparam int RW = 3 * W + F + 1;

  // Stage A: split sign and magnitude
  logic           neg_a_q;
  logic [2*W-1:0] mag_a_q;
  logic [2*W-1:0] den_a_q;
  logic [2*W:0]   mag_full;

  assign mag_full = num_i[2*W] ? (2*W+1)'(-num_i) : num_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_a_q <= num_i[2*W];
      mag_a_q <= mag_full[2*W-1:0];
      den_a_q <= den_i;
    end
  end

  // Stage B: scale the numerator and flag quotients beyond W+1 bits
  logic [RW-1:0]  rem_q [W+2];
  logic [2*W-1:0] den_q [W+2];
  logic [W:0]     quo_q [W+2];
  logic           neg_q [W+2];
  logic           ovf_q [W+2];
  logic [RW-1:0]  rem_b;
  logic [RW-1:0]  lim_b;

  assign rem_b = RW'(mag_a_q) << F;
  assign lim_b = RW'(den_a_q) << (W + 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_b;
      den_q[0] <= den_a_q;
      quo_q[0] <= '0;
      neg_q[0] <= neg_a_q;
      ovf_q[0] <= (rem_b >= lim_b);
    end
  end

  // Bit stages: resolve quotient bit W-s in stage s
  for (genvar s = 0; s <= W; s++) begin : g_step
    localparam int K = W - s;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = RW'(den_q[s]) << K;
    assign ge  = (rem_q[s] >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? (rem_q[s] - dsh) : rem_q[s];
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= quo_q[s] | ((W+1)'(ge) << K);
        neg_q[s+1] <= neg_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  assign quo_o = quo_q[W+1];
  assign neg_o = neg_q[W+1];
  assign ovf_o = ovf_q[W+1];

endmodule

/* hw/rtl/cdiv_checker.sv */
// Port-level checks for the complex divider.
module cdiv_checker #(
  parameter int WIDTH = cdiv_pkg::WIDTH
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic signed [WIDTH-1:0] dividend_re_i,
  input logic signed [WIDTH-1:0] dividend_im_i,
  input logic signed [WIDTH-1:0] divisor_re_i,
  input logic signed [WIDTH-1:0] divisor_im_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [WIDTH-1:0] quot_re_o,
  input logic signed [WIDTH-1:0] quot_im_o,
  input logic [1:0]              status_o
);

  localparam logic signed [WIDTH-1:0] MAX_V = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] MIN_V = {1'b1, {(WIDTH-1){1'b0}}};

  // A zero divisor yields a zero quotient
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cdiv_pkg::STAT_ZERO) |-> (quot_re_o == '0 && quot_im_o == '0))
    else $error("zero divisor word with nonzero quotient");

  // A saturated word has at least one part at a clamp value
  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == cdiv_pkg::STAT_SAT) |->
      (quot_re_o == MAX_V || quot_re_o == MIN_V || quot_im_o == MAX_V || quot_im_o == MIN_V))
    else $error("saturated status without a clamped part");

  // A held output word backs up into the input
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output word is held");

  // A held output word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(quot_re_o) && $stable(quot_im_o) && $stable(status_o)))
    else $error("held output word changed");

endmodule

bind complex_divider cdiv_checker #(.WIDTH(WIDTH)) u_cdiv_checker (.*);
